/* src/u8u16_pkg.sv */
`default_nettype none
package u8u16_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CodeW = 21;
  localparam int unsigned UnitW = 16;

  // Masks for lead and first-trail checks.
  localparam logic [7:0]  Lead2Mask    = 8'h1E;
  localparam logic [7:0]  LowNibble    = 8'h0F;
  localparam logic [7:0]  TrailBit5    = 8'h20;
  localparam logic [15:0] PlaneMask    = 16'h0730;
  localparam logic [15:0] PlaneTopBit  = 16'h0400;
  localparam logic [15:0] PlaneLowMask = 16'h0330;
  localparam logic [CodeW-1:0] SuppBase = 21'h10000;

  localparam logic [5:0] HighSurPrefix = 6'b110110;
  localparam logic [5:0] LowSurPrefix  = 6'b110111;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // All results caused by one accepted byte. The second result, when
  // present, is always a valid unit with status OK.
  typedef struct packed {
    logic              two;
    logic [UnitW-1:0]  unit0;
    logic              valid0;
    status_t           status0;
    logic              done0;
    logic [UnitW-1:0]  unit1;
    logic              done1;
  } rec_t;

endpackage
`default_nettype wire

/* src/u8u16_front.sv */
`default_nettype none
module u8u16_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           strict_mode,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire logic           end_of_string,
  output logic                push,
  output u8u16_pkg::rec_t     push_rec
);

  logic [1:0]                    trail_left_r, trail_left_nxt;
  logic                          pair_pending_r, pair_pending_nxt;
  logic [u8u16_pkg::CodeW-1:0]   code_accum_r, code_accum_nxt;
  logic                          check_pending_r, check_pending_nxt;
  logic [7:0]                    held_lead_r, held_lead_nxt;
  logic                          any_emitted_r, any_emitted_nxt;
  logic                          failed_r, failed_nxt;

  logic                          fault;
  logic                          bad;
  logic                          has_unit;
  logic [u8u16_pkg::CodeW-1:0]   acc_new;
  logic [u8u16_pkg::CodeW-1:0]   supp;
  logic [15:0]                   pair_word;
  u8u16_pkg::rec_t               rec;

  assign acc_new   = {code_accum_r[u8u16_pkg::CodeW-7:0], in_byte[5:0]};
  assign supp      = acc_new - u8u16_pkg::SuppBase;
  assign pair_word = {held_lead_r, in_byte};

  always_comb begin
    // First-trail test for E0 leads (overlong) and F0-F7 leads (range).
    if ((held_lead_r & 8'hF0) == 8'hE0) begin
      bad = ((held_lead_r & u8u16_pkg::LowNibble) == 8'h00) &&
            ((in_byte & u8u16_pkg::TrailBit5) == 8'h00);
    end else begin
      bad = ((pair_word & u8u16_pkg::PlaneMask) == 16'h0000) ||
            (((pair_word & u8u16_pkg::PlaneTopBit) != 16'h0000) &&
             ((pair_word & u8u16_pkg::PlaneLowMask) != 16'h0000));
    end
    bad = bad && check_pending_r;
  end

  always_comb begin
    trail_left_nxt    = trail_left_r;
    pair_pending_nxt  = pair_pending_r;
    code_accum_nxt    = code_accum_r;
    check_pending_nxt = check_pending_r;
    held_lead_nxt     = held_lead_r;
    any_emitted_nxt   = any_emitted_r;
    failed_nxt        = failed_r;
    fault             = 1'b0;
    has_unit          = 1'b0;
    push              = 1'b0;
    rec               = '0;

    if (failed_r) begin
      if (end_of_string) begin
        push        = accept;
        rec.status0 = u8u16_pkg::ST_INVALID;
        rec.done0   = 1'b1;
      end
    end else begin
      if (in_byte < 8'h80) begin
        has_unit          = 1'b1;
        rec.unit0         = {8'h00, in_byte};
        trail_left_nxt    = 2'd0;
        pair_pending_nxt  = 1'b0;
        check_pending_nxt = 1'b0;
      end else if (in_byte < 8'hC0) begin
        if (trail_left_r == 2'd0) begin
          pair_pending_nxt = 1'b0;
          fault            = strict_mode;
        end else begin
          if (check_pending_r) begin
            check_pending_nxt = 1'b0;
          end
          if (bad) begin
            trail_left_nxt   = 2'd0;
            pair_pending_nxt = 1'b0;
            fault            = strict_mode;
          end else begin
            code_accum_nxt = acc_new;
            trail_left_nxt = trail_left_r - 2'd1;
            if (trail_left_r == 2'd1) begin
              has_unit = 1'b1;
              if (pair_pending_r) begin
                rec.two          = 1'b1;
                rec.unit0        = {u8u16_pkg::HighSurPrefix, supp[19:10]};
                rec.unit1        = {u8u16_pkg::LowSurPrefix, supp[9:0]};
                pair_pending_nxt = 1'b0;
              end else begin
                rec.unit0 = acc_new[15:0];
              end
            end
          end
        end
      end else begin
        if (trail_left_r != 2'd0 && strict_mode) begin
          fault = 1'b1;
        end else begin
          trail_left_nxt    = 2'd0;
          pair_pending_nxt  = 1'b0;
          check_pending_nxt = 1'b0;
          if (in_byte < 8'hE0) begin
            if ((in_byte & u8u16_pkg::Lead2Mask) == 8'h00) begin
              fault = strict_mode;
            end else begin
              trail_left_nxt = 2'd1;
              code_accum_nxt = {16'h0000, in_byte[4:0]};
            end
          end else if (in_byte < 8'hF0) begin
            trail_left_nxt    = 2'd2;
            code_accum_nxt    = {17'h00000, in_byte[3:0]};
            check_pending_nxt = 1'b1;
            held_lead_nxt     = in_byte;
          end else if (in_byte < 8'hF8) begin
            trail_left_nxt    = 2'd3;
            pair_pending_nxt  = 1'b1;
            code_accum_nxt    = {18'h00000, in_byte[2:0]};
            check_pending_nxt = 1'b1;
            held_lead_nxt     = in_byte;
          end else begin
            fault = strict_mode;
          end
        end
      end

      if (fault) begin
        rec         = '0;
        push        = accept;
        rec.status0 = u8u16_pkg::ST_INVALID;
        rec.done0   = end_of_string;
        failed_nxt  = ~end_of_string;
      end else begin
        rec.valid0 = has_unit;
        if (has_unit) begin
          any_emitted_nxt = 1'b1;
        end
        if (end_of_string) begin
          if (!has_unit) begin
            if (strict_mode && trail_left_nxt != 2'd0) begin
              rec.status0 = u8u16_pkg::ST_INVALID;
            end else if (!any_emitted_r) begin
              rec.status0 = u8u16_pkg::ST_EMPTY;
            end else begin
              rec.status0 = u8u16_pkg::ST_OK;
            end
            rec.done0 = 1'b1;
          end else if (rec.two) begin
            rec.done1 = 1'b1;
          end else begin
            rec.done0 = 1'b1;
          end
        end
        push = accept && (has_unit || end_of_string);
      end
    end

    // The closing byte of a string leaves nothing behind.
    if (end_of_string) begin
      trail_left_nxt    = 2'd0;
      pair_pending_nxt  = 1'b0;
      code_accum_nxt    = '0;
      check_pending_nxt = 1'b0;
      held_lead_nxt     = 8'h00;
      any_emitted_nxt   = 1'b0;
      failed_nxt        = 1'b0;
    end
  end

  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trail_left_r    <= 2'd0;
      pair_pending_r  <= 1'b0;
      code_accum_r    <= '0;
      check_pending_r <= 1'b0;
      held_lead_r     <= 8'h00;
      any_emitted_r   <= 1'b0;
      failed_r        <= 1'b0;
    end else if (accept) begin
      trail_left_r    <= trail_left_nxt;
      pair_pending_r  <= pair_pending_nxt;
      code_accum_r    <= code_accum_nxt;
      check_pending_r <= check_pending_nxt;
      held_lead_r     <= held_lead_nxt;
      any_emitted_r   <= any_emitted_nxt;
      failed_r        <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/u8u16_queue.sv */
`default_nettype none
module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u8u16_pkg::rec_t push_rec,
  output logic                 full,
  input  wire logic            pop,
  output u8u16_pkg::rec_t      pop_rec,
  output logic                 empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  u8u16_pkg::rec_t   slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/u8u16_back.sv */
`default_nettype none
module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire u8u16_pkg::rec_t q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          code_unit,
  output logic                 unit_valid,
  output u8u16_pkg::status_t   status,
  output logic                 string_done,
  output logic                 last_of_run
);

  logic                 valid_r;
  logic [15:0]          unit_r;
  logic                 uvalid_r;
  u8u16_pkg::status_t   status_r;
  logic                 done_r;
  logic                 last_r;
  logic                 second_r;
  logic [15:0]          sec_unit_r;
  logic                 sec_done_r;
  logic                 load;

  // The output register takes a new result whenever it is empty or drained.
  assign load  = !valid_r || out_ready;
  assign q_pop = load && !second_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      if (second_r) begin
        valid_r  <= 1'b1;
        second_r <= 1'b0;
      end else begin
        valid_r  <= !q_empty;
        second_r <= !q_empty && q_rec.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        unit_r   <= sec_unit_r;
        uvalid_r <= 1'b1;
        status_r <= u8u16_pkg::ST_OK;
        done_r   <= sec_done_r;
        last_r   <= 1'b1;
      end else begin
        unit_r     <= q_rec.unit0;
        uvalid_r   <= q_rec.valid0;
        status_r   <= q_rec.status0;
        done_r     <= q_rec.done0;
        last_r     <= !q_rec.two;
        sec_unit_r <= q_rec.unit1;
        sec_done_r <= q_rec.done1;
      end
    end
  end

  assign out_valid   = valid_r;
  assign code_unit   = unit_r;
  assign unit_valid  = uvalid_r;
  assign status      = status_r;
  assign string_done = done_r;
  assign last_of_run = last_r;

endmodule
`default_nettype wire

/* src/utf8_to_utf16_decoder_unit.sv */
`default_nettype none
// Channel | Direction | Signals                      | Contents
// in      | sink      | in_tvalid/tready/tdata/tlast | in_byte; tlast = end_of_string
// out     | source    | out_tvalid/tready/tdata/tuser/tlast | code unit, flags, string_done
// cfg     | sink      | cfg_valid/cfg_ready/cfg_data | strict_mode
//
// One byte is accepted per cycle while in_tready is high; it is decoded in the same cycle it is taken.
// Each result is a separate output transfer, so a byte ending a four-byte sequence
// yields two results, a surrogate pair; the record queue absorbs that burst.
// Reset (rst_n low, synchronous) clears the decode state, the queue and strict_mode.
// A stalled output fills the queue, after which in_tready drops.
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] code_unit, [16] last_of_run, zero above
  output logic [2:0]       out_tuser,  // [0] unit_valid, [2:1] status
  output logic             out_tlast,  // string_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // strict_mode
);

  logic                strict_r;
  logic                accept;
  logic                push;
  u8u16_pkg::rec_t     push_rec;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  u8u16_pkg::rec_t     q_rec;
  logic [15:0]         code_unit;
  logic                unit_valid;
  u8u16_pkg::status_t  status;
  logic                string_done;
  logic                last_of_run;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strict_r <= cfg_data;
    end
  end

  u8u16_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .strict_mode   (strict_r),
    .accept        (accept),
    .in_byte       (in_tdata),
    .end_of_string (in_tlast),
    .push          (push),
    .push_rec      (push_rec)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .empty    (q_empty)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_rec       (q_rec),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .code_unit   (code_unit),
    .unit_valid  (unit_valid),
    .status      (status),
    .string_done (string_done),
    .last_of_run (last_of_run)
  );

  assign out_tdata = {7'd0, last_of_run, code_unit};
  assign out_tuser = {status, unit_valid};
  assign out_tlast = string_done;

endmodule
`default_nettype wire

/* src/u8u16_checker.sv */
`default_nettype none
module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A status-only result never carries a code unit.
  a_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[15:0] == 16'h0000))
    else $error("status-only result carries a nonzero code unit");

  // Produced units are always reported with status OK.
  a_unit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == u8u16_pkg::ST_OK))
    else $error("code unit with error status");

  // The result closing a string is the last one its byte caused.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[16])
    else $error("string_done without last_of_run");

  // An empty-string report closes the string and has no unit.
  a_empty_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] == u8u16_pkg::ST_EMPTY) |-> (out_tlast && !out_tuser[0]))
    else $error("empty-string status outside a closing result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output transaction changed");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_checker (.*);
`default_nettype wire

/* test/tb_utf8_to_utf16_decoder_unit.sv */
`timescale 1ns / 1ps
module tb_utf8_to_utf16_decoder_unit;
  import u8u16_pkg::*;

  typedef struct packed {
    logic [15:0] code;
    logic        valid;
    status_t     status;
    logic        done;
    logic        last;
  } unit_res_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        strict;
    logic        typed;
    logic [15:0] code;
    logic        valid;
    status_t     status;
    logic        done;
  } dir_row_t;

  localparam int DirRows = 27;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // end_of_string
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] code_unit, [16] last_of_run, zero above
  logic [2:0]  out_tuser;  // [0] unit_valid, [2:1] status
  logic        out_tlast;  // string_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;   // strict_mode

  utf8_to_utf16_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Decoder state mirrored by the testbench.
  logic        strict_now;
  logic [1:0]  t_left;
  logic        t_pair;
  logic [20:0] t_acc;
  logic        t_check;
  logic [7:0]  t_lead;
  logic        t_any;
  logic        t_failed;

  unit_res_t   units_due [$];
  dir_row_t    dir_rows [DirRows];

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int units_checked;
  int strings_closed;
  int strict_faults;
  int empty_strings;
  int miscompares;

  logic [23:0] got_data;
  logic [2:0]  got_user;
  logic        got_last;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #2_000_000;
    $display("tb_utf8_to_utf16_decoder_unit: done, errors");
    $finish;
  end

  function automatic unit_res_t mk_res(input logic [15:0] code, input logic valid,
                                       input status_t status, input logic done,
                                       input logic last);
    unit_res_t r;
    r.code   = code;
    r.valid  = valid;
    r.status = status;
    r.done   = done;
    r.last   = last;
    return r;
  endfunction

  function automatic void clear_string_state();
    t_left   = 2'd0;
    t_pair   = 1'b0;
    t_acc    = '0;
    t_check  = 1'b0;
    t_lead   = 8'h00;
    t_any    = 1'b0;
    t_failed = 1'b0;
  endfunction

  // Appends the code units and status results that one accepted byte causes.
  function automatic void transcode_byte(input logic [7:0] b, input logic eos);
    unit_res_t   r [2];
    int          n;
    logic        fault;
    logic        bad;
    logic        invalid;
    logic [15:0] w;
    logic [19:0] v;
    status_t     st;
    n     = 0;
    fault = 1'b0;
    r[0]  = '0;
    r[1]  = '0;
    if (t_failed) begin
      if (eos) begin
        units_due.push_back(mk_res(16'h0000, 1'b0, ST_INVALID, 1'b1, 1'b1));
        clear_string_state();
      end
      return;
    end
    if (b < 8'h80) begin
      r[n] = mk_res({8'h00, b}, 1'b1, ST_OK, 1'b0, 1'b0);
      n++;
      t_left  = 2'd0;
      t_pair  = 1'b0;
      t_check = 1'b0;
    end else if (b < 8'hC0) begin
      if (t_left == 2'd0) begin
        t_pair = 1'b0;
        fault  = strict_now;
      end else begin
        bad = 1'b0;
        if (t_check) begin
          t_check = 1'b0;
          if (t_lead[7:4] == 4'hE) begin
            bad = ((t_lead & LowNibble) == 8'h00) && ((b & TrailBit5) == 8'h00);
          end else begin
            w   = {t_lead, b};
            bad = ((w & PlaneMask) == 16'h0000) ||
                  (((w & PlaneTopBit) != 16'h0000) && ((w & PlaneLowMask) != 16'h0000));
          end
        end
        if (bad) begin
          t_left = 2'd0;
          t_pair = 1'b0;
          fault  = strict_now;
        end else begin
          t_acc  = {t_acc[14:0], b[5:0]};
          t_left = t_left - 2'd1;
          if (t_left == 2'd0) begin
            if (t_pair) begin
              v    = t_acc[19:0] - SuppBase[19:0];
              r[0] = mk_res({HighSurPrefix, v[19:10]}, 1'b1, ST_OK, 1'b0, 1'b0);
              r[1] = mk_res({LowSurPrefix, v[9:0]}, 1'b1, ST_OK, 1'b0, 1'b0);
              n    = 2;
              t_pair = 1'b0;
            end else begin
              r[n] = mk_res(t_acc[15:0], 1'b1, ST_OK, 1'b0, 1'b0);
              n++;
            end
          end
        end
      end
    end else begin
      if (t_left != 2'd0 && strict_now) begin
        fault = 1'b1;
      end else begin
        invalid = 1'b0;
        t_left  = 2'd0;
        t_pair  = 1'b0;
        t_check = 1'b0;
        if (b < 8'hE0) begin
          if ((b & Lead2Mask) == 8'h00) begin
            invalid = 1'b1;
          end else begin
            t_left = 2'd1;
            t_acc  = {16'h0000, b[4:0]};
          end
        end else if (b < 8'hF0) begin
          t_left  = 2'd2;
          t_acc   = {17'h00000, b[3:0]};
          t_check = 1'b1;
          t_lead  = b;
        end else if (b < 8'hF8) begin
          t_left  = 2'd3;
          t_pair  = 1'b1;
          t_acc   = {18'h00000, b[2:0]};
          t_check = 1'b1;
          t_lead  = b;
        end else begin
          invalid = 1'b1;
        end
        fault = invalid && strict_now;
      end
    end

    if (fault) begin
      units_due.push_back(mk_res(16'h0000, 1'b0, ST_INVALID, eos, 1'b1));
      if (eos) clear_string_state();
      else t_failed = 1'b1;
      return;
    end

    if (n > 0) t_any = 1'b1;
    if (eos) begin
      if (n == 0) begin
        if (strict_now && t_left != 2'd0) st = ST_INVALID;
        else if (!t_any) st = ST_EMPTY;
        else st = ST_OK;
        r[0] = mk_res(16'h0000, 1'b0, st, 1'b1, 1'b0);
        n = 1;
      end else begin
        r[n-1].done = 1'b1;
      end
      clear_string_state();
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) units_due.push_back(r[k]);
  endfunction

  task automatic report_miscompare(input string what);
    miscompares++;
    if (miscompares <= 10) $display("%0t: %s", $time, what);
  endtask

  // Results are captured at the edge and compared once the sender side has
  // recorded any byte accepted at that same edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_data = out_tdata;
      got_user = out_tuser;
      got_last = out_tlast;
      #1;
      if (units_due.size() == 0) begin
        report_miscompare($sformatf("unexpected result: tdata %h tuser %h tlast %b",
                                    got_data, got_user, got_last));
      end else begin
        unit_res_t want;
        want = units_due.pop_front();
        units_checked++;
        if (got_last) strings_closed++;
        if (!got_user[0] && got_user[2:1] == ST_INVALID) strict_faults++;
        if (!got_user[0] && got_user[2:1] == ST_EMPTY) empty_strings++;
        if (got_data != {7'd0, want.last, want.code} ||
            got_user != {want.status, want.valid} || got_last != want.done)
          report_miscompare($sformatf(
            "miscompare: want code %h valid %b status %0d done %b last %b, got %s",
            want.code, want.valid, want.status, want.done, want.last,
            $sformatf("tdata %h tuser %h tlast %b", got_data, got_user, got_last)));
      end
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input unit_res_t fixed);
    int mark;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eos;
    do @(posedge clk); while (!in_tready);
    mark = units_due.size();
    transcode_byte(b, eos);
    if (typed) begin
      while (units_due.size() > mark) void'(units_due.pop_back());
      units_due.push_back(fixed);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (units_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_strict(input logic v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    strict_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] any_trail();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic logic [20:0] pick_point(input int lo, input int hi);
    int r;
    r = $urandom_range(7);
    if (r == 0) return 21'(lo);
    if (r == 1) return 21'(hi);
    return 21'($urandom_range(hi, lo));
  endfunction

  // Mostly well-formed characters, with truncated, overlong, out-of-range
  // and raw noise bytes mixed in.
  task automatic send_random_string();
    logic [7:0]  seq [$];
    logic [7:0]  enc [4];
    logic [20:0] cp;
    logic [7:0]  lead;
    int          chunks;
    int          kind;
    int          len;
    int          keep;
    chunks = $urandom_range(1, 6);
    if ($urandom_range(99) < 5) begin
      seq.push_back(8'($urandom_range(255)));
    end else begin
      for (int c = 0; c < chunks; c++) begin
        kind = $urandom_range(99);
        if (kind < 20) begin
          seq.push_back(8'($urandom_range(127)));
        end else if (kind < 80) begin
          len = $urandom_range(2, 4);
          case (len)
            2: begin
              cp     = pick_point(32'h80, 32'h7FF);
              enc[0] = {3'b110, cp[10:6]};
              enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
              cp     = pick_point(32'h800, 32'hFFFF);
              enc[0] = {4'b1110, cp[15:12]};
              enc[1] = {2'b10, cp[11:6]};
              enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
              cp     = pick_point(32'h10000, 32'h10FFFF);
              enc[0] = {5'b11110, cp[20:18]};
              enc[1] = {2'b10, cp[17:12]};
              enc[2] = {2'b10, cp[11:6]};
              enc[3] = {2'b10, cp[5:0]};
            end
          endcase
          keep = len;
          if (kind >= 68) keep = $urandom_range(1, len - 1);
          for (int k = 0; k < keep; k++) seq.push_back(enc[k]);
        end else if (kind < 90) begin
          case ($urandom_range(3))
            0: begin
              seq.push_back(8'hC0 | 8'($urandom_range(1)));
              seq.push_back(any_trail());
            end
            1: begin
              seq.push_back(8'hE0);
              seq.push_back(8'h80 | 8'($urandom_range(31)));
              seq.push_back(any_trail());
            end
            2: begin
              seq.push_back(8'hF0);
              seq.push_back(8'h80 | 8'($urandom_range(15)));
              seq.push_back(any_trail());
              seq.push_back(any_trail());
            end
            default: begin
              lead = 8'($urandom_range(8'hF7, 8'hF4));
              seq.push_back(lead);
              if (lead == 8'hF4) seq.push_back(8'h90 + 8'($urandom_range(47)));
              else seq.push_back(any_trail());
              seq.push_back(any_trail());
              seq.push_back(any_trail());
            end
          endcase
        end else begin
          seq.push_back(8'($urandom_range(255)));
        end
      end
    end
    for (int k = 0; k < seq.size(); k++)
      push_byte(seq[k], k == seq.size() - 1, 1'b0, '0);
  endtask

  initial begin
    int target;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    strict_now = 1'b0;
    clear_string_state();
    send_idle_pct  = 26;
    recv_idle_pct  = 71;
    bytes_sent     = 0;
    units_checked  = 0;
    strings_closed = 0;
    strict_faults  = 0;
    empty_strings  = 0;
    miscompares    = 0;

    dir_rows = '{
      // Relaxed mode: ASCII extremes, then one character of each length.
      '{8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, ST_OK, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 1'b1, 16'h007F, 1'b1, ST_OK, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hA9, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h82, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hAC, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h98, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      // Everything here is dropped, so the string ends empty.
      '{8'hC0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hE0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h90, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 1'b1},
      // An ASCII byte silently abandons an open sequence.
      '{8'hC3, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h41, 1'b1, 1'b0, 1'b1, 16'h0041, 1'b1, ST_OK, 1'b1},
      // Strict mode faults.
      '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, ST_INVALID, 1'b1},
      '{8'h80, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, ST_INVALID, 1'b0},
      '{8'h42, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, ST_INVALID, 1'b1},
      '{8'hE2, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'h82, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, ST_INVALID, 1'b1},
      '{8'hC3, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK, 1'b0},
      '{8'hC3, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, ST_INVALID, 1'b1}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_strict(1'b0);
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].strict != strict_now) begin
        settle();
        write_strict(dir_rows[i].strict);
      end
      push_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed,
                mk_res(dir_rows[i].code, dir_rows[i].valid, dir_rows[i].status,
                       dir_rows[i].done, 1'b1));
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_strict(p % 2 == 0);
      target = bytes_sent + 190;
      while (bytes_sent < target) send_random_string();
    end
    settle();

    while (units_due.size() != 0) begin
      unit_res_t left;
      left = units_due.pop_front();
      report_miscompare($sformatf("missing result: code %h valid %b status %0d done %b",
                                  left.code, left.valid, left.status, left.done));
    end

    $display("Sent %0d bytes in both modes under three idle patterns; checked %0d results.",
             bytes_sent, units_checked);
    $display("Strings closed: %0d, strict faults: %0d, empty strings: %0d, mismatches: %0d.",
             strings_closed, strict_faults, empty_strings, miscompares);
    if (miscompares == 0) begin
      $display("tb_utf8_to_utf16_decoder_unit: done, clean");
    end else begin
      $display("tb_utf8_to_utf16_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule

/* utf8_to_utf16_decoder_unit.f */
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_decoder_unit.sv
src/u8u16_checker.sv
test/tb_utf8_to_utf16_decoder_unit.sv
